/* rtl/assert_macros.svh */
// Assertion macros shared by the connection tracker RTL.
// Depends on nothing; the SYNTH macro removes the checks for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

/* rtl/tcpct_pkg.sv */
// Package of the TCP connection tracker: table size, flag masks, states.
// Depends on nothing.
`default_nettype none
package tcpct_pkg;
   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int KEY_W = 96;
   localparam logic [7:0] FLAG_FIN = 8'h01;
   localparam logic [7:0] FLAG_SYN = 8'h02;
   localparam logic [7:0] FLAG_RST = 8'h04;
   localparam logic [7:0] FLAG_ACK = 8'h10;
   localparam logic [1:0] ST_CLOSED = 2'd0;
   localparam logic [1:0] ST_OPEN = 2'd1;
   localparam logic [1:0] ST_HALF = 2'd2;
   localparam logic [1:0] ST_ESTABLISHED = 2'd3;
   localparam logic VERDICT_PASS = 1'b0;
   localparam logic VERDICT_BLOCK = 1'b1;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_DECIDE,
      FSM_RESULT
   } fsm_type;
endpackage
`default_nettype wire

/* rtl/tcp_connection_state_tracker_core.sv */
// TCP connection tracker top level: key table memory, scan sequencer and verdict logic.
// Depends on tcpct_pkg and assert_macros.svh.
//
// Usage: an item on the req_ channel carries one packet header and a rule
// verdict; one item on the rsp_ channel returns verdict, table_full and the
// connection state after the packet. The key table sits in a memory with a
// registered read; each item reads every entry in turn, one entry per cycle,
// to find a match, takes the lowest free entry from the valid bits, and
// then writes back at most once. A new item is taken in the cycle after the
// result has been accepted, so the tracker does not take a new item while
// one is still in flight. The scan length is set by the single read port
// of the table.
// Reset clears the valid bits, which live in flip-flops, and the sequencer;
// the memory needs no clearing pass. When rsp_stall is high the result
// holds in its register, and req_stall stays high until it is taken.
`default_nettype none
`include "assert_macros.svh"
module tcp_connection_state_tracker_core import tcpct_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_source_address,
   input  wire logic [31:0] req_destination_address,
   input  wire logic [15:0] req_source_port,
   input  wire logic [15:0] req_destination_port,
   input  wire logic [7:0]  req_tcp_flags,
   input  wire logic        req_rule_pass,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_verdict,
   output logic             rsp_table_full,
   output logic [1:0]       rsp_connection_state
);
   logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
   logic [1:0] st_mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   fsm_type state_ff, state_in;
   logic [IDX_W:0] rd_cnt_ff, rd_cnt_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic cmp_live_ff, cmp_live_in;
   logic [KEY_W-1:0] rd_key_ff;
   logic [1:0] rd_st_ff;

   logic [KEY_W-1:0] key_ff, key_in;
   logic [7:0] flags_ff, flags_in;
   logic pass_ff, pass_in;
   logic hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [1:0] hit_st_ff, hit_st_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic verdict_ff, verdict_in;
   logic full_ff, full_in;
   logic [1:0] cstate_ff, cstate_in;

   logic wr_en;
   logic wr_key;
   logic [IDX_W-1:0] wr_idx;
   logic [1:0] wr_st;
   logic free_any;
   logic [IDX_W-1:0] free_idx;
   logic lo_src;
   logic [KEY_W-1:0] req_key;
   logic accept;

   assign lo_src = (req_source_address < req_destination_address) ||
      ((req_source_address == req_destination_address) &&
       (req_source_port <= req_destination_port));
   assign req_key = lo_src ?
      {req_source_address, req_destination_address, req_source_port, req_destination_port} :
      {req_destination_address, req_source_address, req_destination_port, req_source_port};
   assign accept = req_valid && !req_stall;

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            if (rd_cnt_ff == (IDX_W + 1)'(TABLE_ENTRIES)) begin
               state_in = FSM_DECIDE;
            end
         end
         FSM_DECIDE: state_in = FSM_RESULT;
         FSM_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != FSM_IDLE);
      rd_cnt_in = rd_cnt_ff;
      cmp_live_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      key_in = key_ff;
      flags_in = flags_ff;
      pass_in = pass_ff;
      hit_in = hit_ff;
      hit_idx_in = hit_idx_ff;
      hit_st_in = hit_st_ff;
      case (state_ff)
         FSM_IDLE: begin
            rd_cnt_in = '0;
            hit_in = 1'b0;
            if (accept) begin
               key_in = req_key;
               flags_in = req_tcp_flags;
               pass_in = req_rule_pass;
            end
         end
         FSM_SCAN: begin
            if (rd_cnt_ff != (IDX_W + 1)'(TABLE_ENTRIES)) begin
               cmp_live_in = 1'b1;
               cmp_idx_in = rd_cnt_ff[IDX_W-1:0];
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (cmp_live_ff && valid_ff[cmp_idx_ff] && rd_key_ff == key_ff && !hit_ff) begin
         hit_in = 1'b1;
         hit_idx_in = cmp_idx_ff;
         hit_st_in = rd_st_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      wr_en = 1'b0;
      wr_key = 1'b0;
      wr_idx = hit_idx_ff;
      wr_st = ST_OPEN;
      verdict_in = verdict_ff;
      full_in = full_ff;
      cstate_in = cstate_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == FSM_DECIDE) begin
         rsp_valid_in = 1'b1;
         verdict_in = VERDICT_BLOCK;
         full_in = 1'b0;
         cstate_in = hit_ff ? hit_st_ff : ST_CLOSED;
         if ((flags_ff & (FLAG_FIN | FLAG_RST)) != 8'h00) begin
            verdict_in = VERDICT_PASS;
            cstate_in = ST_CLOSED;
            if (hit_ff) begin
               valid_in[hit_idx_ff] = 1'b0;
            end
         end else if ((flags_ff & FLAG_SYN) != 8'h00) begin
            if ((flags_ff & FLAG_ACK) != 8'h00) begin
               if (hit_ff && hit_st_ff == ST_OPEN) begin
                  if (pass_ff) begin
                     verdict_in = VERDICT_PASS;
                     wr_en = 1'b1;
                     wr_st = ST_HALF;
                     cstate_in = ST_HALF;
                  end else begin
                     valid_in[hit_idx_ff] = 1'b0;
                     cstate_in = ST_CLOSED;
                  end
               end
            end else if (pass_ff) begin
               verdict_in = VERDICT_PASS;
               if (hit_ff || free_any) begin
                  wr_en = 1'b1;
                  wr_key = 1'b1;
                  wr_st = ST_OPEN;
                  wr_idx = hit_ff ? hit_idx_ff : free_idx;
                  valid_in[wr_idx] = 1'b1;
                  cstate_in = ST_OPEN;
               end else begin
                  full_in = 1'b1;
               end
            end
         end else if ((flags_ff & FLAG_ACK) != 8'h00) begin
            if (hit_ff && hit_st_ff == ST_ESTABLISHED) begin
               verdict_in = VERDICT_PASS;
            end else if (hit_ff && hit_st_ff == ST_HALF) begin
               verdict_in = VERDICT_PASS;
               wr_en = 1'b1;
               wr_st = ST_ESTABLISHED;
               cstate_in = ST_ESTABLISHED;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[rd_cnt_ff[IDX_W-1:0]];
      rd_st_ff <= st_mem[rd_cnt_ff[IDX_W-1:0]];
      if (wr_en) begin
         st_mem[wr_idx] <= wr_st;
         if (wr_key) begin
            key_mem[wr_idx] <= key_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_live_ff <= 1'b0;
         rd_cnt_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_live_ff <= cmp_live_in;
         rd_cnt_ff <= rd_cnt_in;
         hit_ff <= hit_in;
      end
      cmp_idx_ff <= cmp_idx_in;
      key_ff <= key_in;
      flags_ff <= flags_in;
      pass_ff <= pass_in;
      hit_idx_ff <= hit_idx_in;
      hit_st_ff <= hit_st_in;
      verdict_ff <= verdict_in;
      full_ff <= full_in;
      cstate_ff <= cstate_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;
   assign rsp_table_full = full_ff;
   assign rsp_connection_state = cstate_ff;

   `ASSERT_NEXT(a_decide_gives_result, clock, reset, state_ff == FSM_DECIDE, rsp_valid_ff)
   `ASSERT_IMPLIES(a_full_means_pass, clock, reset, rsp_valid_ff && full_ff, !verdict_ff && cstate_ff == ST_CLOSED)
   `ASSERT_IMPLIES(a_no_accept_busy, clock, reset, state_ff != FSM_IDLE, req_stall)
   `ASSERT_IMPLIES(a_write_in_decide, clock, reset, wr_en, state_ff == FSM_DECIDE)
endmodule
`default_nettype wire

/* test/tb_tcp_connection_state_tracker_core.sv */
// Self-checking testbench for the TCP connection tracker core: drives packet headers and
// compares each verdict, table-full flag and connection state with a behavioural predictor.
// Depends on tcpct_pkg and the tcp_connection_state_tracker_core RTL.
module tb_tcp_connection_state_tracker_core;
   import tcpct_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        verdict;
      logic        table_full;
      logic [1:0]  conn_state;
   } outcome_type;

   typedef struct {
      logic [31:0] sa;
      logic [31:0] da;
      logic [15:0] sp;
      logic [15:0] dp;
      logic [7:0]  flags;
      logic        pass;
      bit          typed;
      outcome_type want;
   } packet_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_source_address = '0;
   logic [31:0] req_destination_address = '0;
   logic [15:0] req_source_port = '0;
   logic [15:0] req_destination_port = '0;
   logic [7:0]  req_tcp_flags = '0;
   logic        req_rule_pass = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_verdict;
   logic        rsp_table_full;
   logic [1:0]  rsp_connection_state;

   tcp_connection_state_tracker_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_source_address(req_source_address),
      .req_destination_address(req_destination_address),
      .req_source_port(req_source_port),
      .req_destination_port(req_destination_port),
      .req_tcp_flags(req_tcp_flags), .req_rule_pass(req_rule_pass),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_verdict(rsp_verdict), .rsp_table_full(rsp_table_full),
      .rsp_connection_state(rsp_connection_state)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor copy of the connection table.
   bit          conn_used [TABLE_ENTRIES];
   logic [31:0] conn_lo [TABLE_ENTRIES];
   logic [31:0] conn_hi [TABLE_ENTRIES];
   logic [31:0] conn_ports [TABLE_ENTRIES];
   logic [1:0]  conn_st [TABLE_ENTRIES];

   outcome_type pending_outcomes [$];
   int          mismatches = 0;
   int          results_seen = 0;
   int          full_seen = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          stim_done = 0;
   packet_row_type rows [$];

   function automatic outcome_type track_packet(packet_row_type p);
      logic [31:0] lo, hi, ports;
      int          idx, i;
      outcome_type o;
      idx = -1;
      o.verdict = VERDICT_BLOCK;
      o.table_full = 1'b0;
      if (p.sa < p.da || (p.sa == p.da && p.sp <= p.dp)) begin
         lo = p.sa; hi = p.da; ports = {p.sp, p.dp};
      end else begin
         lo = p.da; hi = p.sa; ports = {p.dp, p.sp};
      end
      for (i = 0; i < TABLE_ENTRIES; i++)
         if (idx < 0 && conn_used[i] && conn_lo[i] == lo && conn_hi[i] == hi &&
             conn_ports[i] == ports)
            idx = i;
      if ((p.flags & (FLAG_FIN | FLAG_RST)) != 0) begin
         if (idx >= 0) conn_used[idx] = 0;
         idx = -1;
         o.verdict = VERDICT_PASS;
      end else if ((p.flags & FLAG_SYN) != 0) begin
         if ((p.flags & FLAG_ACK) != 0) begin
            if (idx >= 0 && conn_st[idx] == ST_OPEN) begin
               if (p.pass) begin
                  conn_st[idx] = ST_HALF;
                  o.verdict = VERDICT_PASS;
               end else begin
                  conn_used[idx] = 0;
                  idx = -1;
               end
            end
         end else if (p.pass) begin
            o.verdict = VERDICT_PASS;
            for (i = 0; i < TABLE_ENTRIES; i++)
               if (idx < 0 && !conn_used[i]) idx = i;
            if (idx < 0) begin
               o.table_full = 1'b1;
            end else begin
               conn_used[idx] = 1;
               conn_lo[idx] = lo;
               conn_hi[idx] = hi;
               conn_ports[idx] = ports;
               conn_st[idx] = ST_OPEN;
            end
         end
      end else if ((p.flags & FLAG_ACK) != 0) begin
         if (idx >= 0 && conn_st[idx] == ST_ESTABLISHED) begin
            o.verdict = VERDICT_PASS;
         end else if (idx >= 0 && conn_st[idx] == ST_HALF) begin
            conn_st[idx] = ST_ESTABLISHED;
            o.verdict = VERDICT_PASS;
         end
      end
      o.conn_state = (idx >= 0) ? conn_st[idx] : ST_CLOSED;
      return o;
   endfunction

   function automatic packet_row_type mk(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                                         logic [15:0] dp, logic [7:0] fl, logic ps,
                                         bit typed = 1'b0, outcome_type want = '0);
      packet_row_type r;
      r.sa = sa; r.da = da; r.sp = sp; r.dp = dp; r.flags = fl; r.pass = ps;
      r.typed = typed; r.want = want;
      return r;
   endfunction

   task automatic send_packet(packet_row_type r);
      outcome_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_source_address <= r.sa;
      req_destination_address <= r.da;
      req_source_port <= r.sp;
      req_destination_port <= r.dp;
      req_tcp_flags <= r.flags;
      req_rule_pass <= r.pass;
      do @(posedge clock); while (req_stall);
      predicted = track_packet(r);
      if (r.typed && predicted !== r.want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Table row disagrees with predictor: row %h, predictor %h", r.want,
                     predicted);
      end
      pending_outcomes.push_back(predicted);
   endtask

   always @(posedge clock) begin
      outcome_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_verdict, rsp_table_full, rsp_connection_state};
         results_seen++;
         if (got.table_full) full_seen++;
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result %h", got);
         end else begin
            want = pending_outcomes.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected verdict %0d full %0d state %0d, got %0d %0d %0d",
                           want.verdict, want.table_full, want.conn_state,
                           got.verdict, got.table_full, got.conn_state);
            end
         end
      end
      if (!reset) rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // A small pool of endpoints so that connections recur and go through their states.
   function automatic packet_row_type random_packet(int pool);
      packet_row_type r;
      int          k, fsel;
      logic [7:0]  fl;
      k = $urandom_range(pool - 1);
      r = mk(32'h0A00_0000 + k * 7, 32'hC0A8_0000 - k, 16'(1000 + k), 16'd80,
             8'h00, $urandom_range(99) < 85);
      if ($urandom_range(1)) begin
         {r.sa, r.da, r.sp, r.dp} = {r.da, r.sa, r.dp, r.sp};
      end
      fsel = $urandom_range(99);
      fl = 8'($urandom) & 8'hEA;
      if (fsel < 30) fl = fl & ~FLAG_ACK | FLAG_SYN;
      else if (fsel < 55) fl = fl | FLAG_SYN | FLAG_ACK;
      else if (fsel < 85) fl = fl & ~FLAG_SYN | FLAG_ACK;
      else if (fsel < 93) fl = 8'($urandom);
      else begin
         r = mk($urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom),
                1'($urandom_range(1)));
         fl = r.flags;
      end
      r.flags = fl;
      return r;
   endfunction

   initial begin
      int n, phase, pool;
      for (n = 0; n < TABLE_ENTRIES; n++) conn_used[n] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      rows.push_back(mk(32'd1, 32'd2, 16'd5, 16'd6, FLAG_ACK, 1'b1, 1'b1,
                        '{VERDICT_BLOCK, 1'b0, ST_CLOSED}));
      rows.push_back(mk(32'd1, 32'd2, 16'd5, 16'd6, FLAG_SYN, 1'b0, 1'b1,
                        '{VERDICT_BLOCK, 1'b0, ST_CLOSED}));
      rows.push_back(mk(32'd1, 32'd2, 16'd5, 16'd6, FLAG_SYN, 1'b1, 1'b1,
                        '{VERDICT_PASS, 1'b0, ST_OPEN}));
      rows.push_back(mk(32'd2, 32'd1, 16'd6, 16'd5, FLAG_SYN | FLAG_ACK, 1'b1, 1'b1,
                        '{VERDICT_PASS, 1'b0, ST_HALF}));
      rows.push_back(mk(32'd1, 32'd2, 16'd5, 16'd6, FLAG_ACK, 1'b0, 1'b1,
                        '{VERDICT_PASS, 1'b0, ST_ESTABLISHED}));
      rows.push_back(mk(32'd2, 32'd1, 16'd6, 16'd5, 8'hFF & ~FLAG_FIN, 1'b1));
      rows.push_back(mk(32'd1, 32'd2, 16'd5, 16'd6, 8'hFF, 1'b1, 1'b1,
                        '{VERDICT_PASS, 1'b0, ST_CLOSED}));
      rows.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, FLAG_SYN, 1'b1));
      rows.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 16'hFFFF, FLAG_SYN | FLAG_ACK,
                        1'b0));
      rows.push_back(mk(32'd0, 32'd0, 16'd0, 16'd0, FLAG_SYN, 1'b1));
      rows.push_back(mk(32'd0, 32'd0, 16'd0, 16'd0, 8'hE8, 1'b1, 1'b1,
                        '{VERDICT_BLOCK, 1'b0, ST_OPEN}));
      rows.push_back(mk(32'd0, 32'd0, 16'd0, 16'd0, FLAG_ACK, 1'b1));
      rows.push_back(mk(32'd0, 32'd0, 16'd0, 16'd0, FLAG_RST, 1'b0));
      foreach (rows[i]) send_packet(rows[i]);
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 51 : 0;
         recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 26 : 0;
         for (n = 0; n < 670; n++) begin
            // One stretch per phase floods the table with more connections than it holds.
            pool = (n >= 300 && n < 420) ? 90 : 24;
            if (pool == 90 && $urandom_range(1)) begin
               send_packet(mk(32'h0A00_0000 + n, 32'h0B00_0000, 16'($urandom), 16'd443,
                              FLAG_SYN, 1'b1));
            end else begin
               send_packet(random_packet(pool));
            end
         end
      end
      req_valid <= 1'b0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4 * (TABLE_ENTRIES + 3)) @(posedge clock);
      $display("Sent about 2000 packets through handshakes, flag mixes and table overflow.");
      $display("Results checked: %0d, table-full results: %0d, mismatches: %0d",
               results_seen, full_seen, mismatches);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("Timed out");
      $display("Test completed with failures");
      $finish;
   end
endmodule
